@@ sv/emg_bandpass_rms_envelope_core_macros.svh @@
// Assertion macros for the EMG envelope core.
// Used by the top level; needs nothing else.
`ifndef EMG_BANDPASS_RMS_ENVELOPE_CORE_MACROS_SVH
`define EMG_BANDPASS_RMS_ENVELOPE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define EMG_ASSERT(lbl, c, r, p, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) else $error(msg);
`define EMG_ASSERT_IMPLY(lbl, c, r, a, b, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) else $error(msg);
`else
`define EMG_ASSERT(lbl, c, r, p, msg)
`define EMG_ASSERT_IMPLY(lbl, c, r, a, b, msg)
`endif
`endif

@@ sv/emg_rms_pkg.sv @@
// Shared types, constants and filter tables of the EMG envelope core.
// No dependencies.
`default_nettype none
package emg_rms_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int WINDOW_DEF   = 10;
  localparam int FIFO_DEPTH   = 2;
  localparam int CHIN_W       = 3;
  localparam int RAW_W        = 24;
  localparam int Q_W          = 16;
  localparam int SQ_W         = 31;
  localparam int SUM_W        = 35;
  localparam int ENV_W        = 15;
  localparam int TERM_W       = 4;
  localparam int TERMS        = 10;
  localparam int HP_TERMS     = 5;
  localparam int NEWTON_STEPS = 3;

  localparam logic [ENV_W-1:0] ENV_MAX = 15'h7FFF;

  localparam logic signed [Q_W-1:0] HP_B0 = 16'sh7B50;
  localparam logic signed [Q_W-1:0] HP_B1 = 16'sh84AF;
  localparam logic signed [Q_W-1:0] HP_B2 = 16'sh7B50;
  localparam logic signed [Q_W-1:0] HP_A1 = 16'sh84AF;
  localparam logic signed [Q_W-1:0] HP_A2 = 16'sh76A0;
  localparam logic signed [Q_W-1:0] LP_B0 = 16'sh0F82;
  localparam logic signed [Q_W-1:0] LP_B1 = 16'sh1F04;
  localparam logic signed [Q_W-1:0] LP_B2 = 16'sh0F82;
  localparam logic signed [Q_W-1:0] LP_A1 = 16'sh6E4B;
  localparam logic signed [Q_W-1:0] LP_A2 = 16'shCE51;

  typedef struct packed {
    logic signed [Q_W-1:0] x1;
    logic signed [Q_W-1:0] x2;
    logic signed [Q_W-1:0] y1;
    logic signed [Q_W-1:0] y2;
    logic signed [Q_W-1:0] z1;
    logic signed [Q_W-1:0] z2;
    logic [SUM_W-1:0]      sum;
  } chan_state_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOAD,
    BK_UNPACK,
    BK_MUL,
    BK_ACC,
    BK_SQUARE,
    BK_UPDATE,
    BK_MEAN,
    BK_ROOT,
    BK_OUT
  } back_state_t;

  // Coefficient of each filter term: high-pass terms first, then low-pass.
  function automatic logic signed [Q_W-1:0] term_coef(input logic [TERM_W-1:0] k);
    case (k)
      4'd0:    return HP_B0;
      4'd1:    return HP_B1;
      4'd2:    return HP_B2;
      4'd3:    return HP_A1;
      4'd4:    return HP_A2;
      4'd5:    return LP_B0;
      4'd6:    return LP_B1;
      4'd7:    return LP_B2;
      4'd8:    return LP_A1;
      4'd9:    return LP_A2;
      default: return '0;
    endcase
  endfunction

  // Feedback terms are subtracted.
  function automatic logic term_neg(input logic [TERM_W-1:0] k);
    return (k == 4'd3) || (k == 4'd4) || (k == 4'd8) || (k == 4'd9);
  endfunction

  // Floor shift of a Q30 product to Q15, saturated.
  function automatic logic signed [Q_W-1:0] qsat(input logic signed [31:0] p);
    logic signed [16:0] t;
    t = p[31:15];
    if (t > 17'sd32767) return 16'sh7FFF;
    else if (t < $signed(17'h18000)) return 16'sh8000;
    else return t[15:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/emg_rms_fifo.sv @@
// Short item queue between the front and back parts.
// Generic width; uses emg_rms_pkg for the status struct.
`default_nettype none
module emg_rms_fifo #(
  parameter int WIDTH = 22,
  parameter int DEPTH = emg_rms_pkg::FIFO_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic [WIDTH-1:0]                rdata,
  output emg_rms_pkg::fifo_status_t       status
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rdata        = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(DEPTH));
endmodule
`default_nettype wire

@@ sv/emg_rms_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; no package use.
`default_nettype none
module emg_rms_div #(
  parameter int DW = 35
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic          ge;

  assign shifted = {rem, quotient[DW-1]};
  assign ge      = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
      cnt      <= CW'(DW - 1);
    end else if (busy) begin
      rem      <= ge ? DW'(shifted - {1'b0, dsr}) : shifted[DW-1:0];
      quotient <= {quotient[DW-2:0], ge};
      cnt      <= cnt - 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ sv/emg_rms_front.sv @@
// Front part: takes input transactions, maps the channel, extracts Q15.
// Uses emg_rms_pkg for status structs.
`default_nettype none
module emg_rms_front #(
  parameter int CHANNELS = emg_rms_pkg::CHANNELS_DEF,
  parameter int CHW      = 3
) (
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [emg_rms_pkg::CHIN_W-1:0]     channel_index,
  input  wire logic signed [emg_rms_pkg::RAW_W-1:0] adc_sample,
  input  wire emg_rms_pkg::fifo_status_t          fifo_st,
  input  wire emg_rms_pkg::back_ctl_t             back_ctl,
  output logic                                    push,
  output logic [CHW-1:0]                          item_ch,
  output logic [emg_rms_pkg::CHIN_W-1:0]          item_chin,
  output logic signed [emg_rms_pkg::Q_W-1:0]      item_x
);
  function automatic logic [CHW-1:0] map_channel(
      input logic [emg_rms_pkg::CHIN_W-1:0] c);
    logic [emg_rms_pkg::CHIN_W-1:0] v;
    v = c;
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= CHANNELS) v = v - emg_rms_pkg::CHIN_W'(CHANNELS);
    end
    return CHW'(v);
  endfunction

  // Hold off while the queue is full or the stores are being cleared.
  assign in_stall  = fifo_st.full || back_ctl.clearing;
  assign push      = in_valid && !in_stall;
  assign item_ch   = map_channel(channel_index);
  assign item_chin = channel_index;
  assign item_x    = {adc_sample[23], adc_sample[23:9]};
endmodule
`default_nettype wire

@@ sv/emg_rms_back.sv @@
// Back part: filters, square ring, running sum, mean and Newton root.
// Uses emg_rms_pkg and the serial divider emg_rms_div.
`default_nettype none
module emg_rms_back #(
  parameter int CHANNELS = emg_rms_pkg::CHANNELS_DEF,
  parameter int WINDOW   = emg_rms_pkg::WINDOW_DEF,
  parameter int CHW      = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire emg_rms_pkg::fifo_status_t         fifo_st,
  input  wire logic [CHW-1:0]                    item_ch,
  input  wire logic [emg_rms_pkg::CHIN_W-1:0]    item_chin,
  input  wire logic signed [emg_rms_pkg::Q_W-1:0] item_x,
  output emg_rms_pkg::back_ctl_t                 ctl,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [emg_rms_pkg::ENV_W-1:0]          envelope,
  output logic [emg_rms_pkg::CHIN_W-1:0]         channel_echo
);
  localparam int PW    = $clog2(WINDOW);
  localparam int RA    = $clog2(CHANNELS * WINDOW);
  localparam int Q_W   = emg_rms_pkg::Q_W;
  localparam int SQ_W  = emg_rms_pkg::SQ_W;
  localparam int SUM_W = emg_rms_pkg::SUM_W;
  localparam int ENV_W = emg_rms_pkg::ENV_W;

  // Mean by reciprocal multiplication, one 12-bit slice of the sum per cycle.
  localparam int MC_W        = 12;
  localparam int MEAN_CHUNKS = (SUM_W + MC_W - 1) / MC_W;
  localparam int MN_W        = MEAN_CHUNKS * MC_W;
  localparam int MW          = SUM_W + 1;
  localparam int PP_W        = MC_W + MW;
  localparam int MA_W        = MN_W + MW;
  localparam int RSH         = SUM_W + $clog2(WINDOW);
  localparam logic [63:0] RECIP64 =
      ((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

  emg_rms_pkg::back_state_t state, state_next;

  emg_rms_pkg::chan_state_t chan_mem [CHANNELS];
  logic [PW-1:0]            pos_mem  [CHANNELS];
  logic [SQ_W-1:0]          ring_mem [CHANNELS*WINDOW];

  emg_rms_pkg::chan_state_t chan_q, chan_wd;
  logic [PW-1:0]   pos_q, pos_wd;
  logic [SQ_W-1:0] ring_q, ring_wd;
  logic            chan_we, ring_we;
  logic [CHW-1:0]  chan_wa;
  logic [RA-1:0]   ring_wa;

  logic [RA-1:0]   clr_cnt;
  logic [CHW-1:0]  cur_ch;
  logic [emg_rms_pkg::CHIN_W-1:0] chin_r;
  logic signed [Q_W-1:0] xin, x1, x2, y1, y2, z1, z2, hp, acc, acc_next;
  logic signed [Q_W-1:0] opnd;
  logic signed [31:0]    prod;
  logic [emg_rms_pkg::TERM_W-1:0] k;
  logic [16:0]     rect;
  logic [SQ_W-1:0] sq;
  logic [SUM_W-1:0] sum, sum_new;
  logic [PW-1:0]   pos, pos_next;
  logic [RA-1:0]   ring_addr;
  logic [SUM_W-1:0] s_r, r, r_next;
  logic [SUM_W:0]  r_sum;
  logic [1:0]      it;
  logic [ENV_W-1:0] env_r;
  logic            out_load;

  logic [MN_W-1:0]  mean_n;
  logic [MA_W-1:0]  mean_acc, mean_acc_next;
  logic [PP_W-1:0]  mean_pp;
  logic [1:0]       mean_cnt;
  logic [SUM_W-1:0] mean_q;

  logic             div_start, div_done;
  logic [SUM_W-1:0] div_dividend, div_divisor, div_quo;

  emg_rms_div #(.DW(SUM_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (chan_we) begin
      chan_mem[chan_wa] <= chan_wd;
      pos_mem[chan_wa]  <= pos_wd;
    end
    chan_q <= chan_mem[cur_ch];
    pos_q  <= pos_mem[cur_ch];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_q <= ring_mem[ring_addr];
  end

  always_comb begin
    unique case (k)
      4'd0:    opnd = xin;
      4'd1:    opnd = x1;
      4'd2:    opnd = x2;
      4'd3:    opnd = y1;
      4'd4:    opnd = y2;
      4'd5:    opnd = hp;
      4'd6:    opnd = y1;
      4'd7:    opnd = y2;
      4'd8:    opnd = z1;
      4'd9:    opnd = z2;
      default: opnd = '0;
    endcase
  end

  assign acc_next = emg_rms_pkg::term_neg(k) ? acc - emg_rms_pkg::qsat(prod)
                                             : acc + emg_rms_pkg::qsat(prod);
  assign rect     = acc[15] ? 17'(-{acc[15], acc}) : {1'b0, acc};
  assign sum_new  = sum - SUM_W'(ring_q) + SUM_W'(sq);
  assign pos_next = (pos == PW'(WINDOW - 1)) ? '0 : pos + 1'b1;
  assign r_sum    = {1'b0, r} + {1'b0, div_quo};
  assign r_next   = (r_sum[SUM_W:1] == '0) ? SUM_W'(1) : r_sum[SUM_W:1];

  assign mean_pp       = PP_W'(mean_n[MN_W-1 -: MC_W]) * PP_W'(RECIP);
  assign mean_acc_next = {mean_acc[MA_W-MC_W-1:0], {MC_W{1'b0}}} + MA_W'(mean_pp);
  assign mean_q        = SUM_W'(mean_acc[MA_W-1:RSH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= emg_rms_pkg::BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl.pop      = 1'b0;
    ctl.clearing = (state == emg_rms_pkg::BK_CLEAR);
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    chan_we      = 1'b0;
    chan_wa      = cur_ch;
    chan_wd      = '{xin, x1, hp, y1, acc, z1, sum_new};
    pos_wd       = pos_next;
    ring_we      = 1'b0;
    ring_wa      = ring_addr;
    ring_wd      = sq;
    out_load     = 1'b0;
    unique case (state)
      emg_rms_pkg::BK_CLEAR: begin
        ring_we = 1'b1;
        ring_wa = clr_cnt;
        ring_wd = '0;
        chan_we = (32'(clr_cnt) < CHANNELS);
        chan_wa = clr_cnt[CHW-1:0];
        chan_wd = '0;
        pos_wd  = '0;
        if (clr_cnt == RA'(CHANNELS * WINDOW - 1)) state_next = emg_rms_pkg::BK_IDLE;
      end
      emg_rms_pkg::BK_IDLE: begin
        if (!fifo_st.empty) begin
          ctl.pop    = 1'b1;
          state_next = emg_rms_pkg::BK_LOAD;
        end
      end
      emg_rms_pkg::BK_LOAD:   state_next = emg_rms_pkg::BK_UNPACK;
      emg_rms_pkg::BK_UNPACK: state_next = emg_rms_pkg::BK_MUL;
      emg_rms_pkg::BK_MUL:    state_next = emg_rms_pkg::BK_ACC;
      emg_rms_pkg::BK_ACC: begin
        state_next = (k == emg_rms_pkg::TERM_W'(emg_rms_pkg::TERMS - 1))
                     ? emg_rms_pkg::BK_SQUARE : emg_rms_pkg::BK_MUL;
      end
      emg_rms_pkg::BK_SQUARE: state_next = emg_rms_pkg::BK_UPDATE;
      emg_rms_pkg::BK_UPDATE: begin
        chan_we    = 1'b1;
        ring_we    = 1'b1;
        state_next = emg_rms_pkg::BK_MEAN;
      end
      emg_rms_pkg::BK_MEAN: begin
        if (mean_cnt == 2'(MEAN_CHUNKS)) begin
          if (mean_q == '0) begin
            state_next = emg_rms_pkg::BK_OUT;
          end else begin
            div_start    = 1'b1;
            div_dividend = mean_q;
            div_divisor  = mean_q;
            state_next   = emg_rms_pkg::BK_ROOT;
          end
        end
      end
      emg_rms_pkg::BK_ROOT: begin
        if (div_done) begin
          if (it == 2'(emg_rms_pkg::NEWTON_STEPS - 1)) begin
            state_next = emg_rms_pkg::BK_OUT;
          end else begin
            div_start    = 1'b1;
            div_dividend = s_r;
            div_divisor  = r_next;
          end
        end
      end
      emg_rms_pkg::BK_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = emg_rms_pkg::BK_IDLE;
        end
      end
      default: state_next = emg_rms_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == emg_rms_pkg::BK_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      emg_rms_pkg::BK_IDLE: begin
        if (ctl.pop) begin
          cur_ch <= item_ch;
          chin_r <= item_chin;
          xin    <= item_x;
        end
      end
      emg_rms_pkg::BK_UNPACK: begin
        x1        <= chan_q.x1;
        x2        <= chan_q.x2;
        y1        <= chan_q.y1;
        y2        <= chan_q.y2;
        z1        <= chan_q.z1;
        z2        <= chan_q.z2;
        sum       <= chan_q.sum;
        pos       <= pos_q;
        ring_addr <= RA'(cur_ch) * RA'(WINDOW) + RA'(pos_q);
        k         <= '0;
        acc       <= '0;
      end
      emg_rms_pkg::BK_MUL: prod <= emg_rms_pkg::term_coef(k) * opnd;
      emg_rms_pkg::BK_ACC: begin
        // The low-pass sum starts fresh once the high-pass output is taken.
        if (k == emg_rms_pkg::TERM_W'(emg_rms_pkg::HP_TERMS - 1)) begin
          hp  <= acc_next;
          acc <= '0;
        end else begin
          acc <= acc_next;
        end
        k <= k + 1'b1;
      end
      emg_rms_pkg::BK_SQUARE: sq <= SQ_W'(rect) * SQ_W'(rect);
      emg_rms_pkg::BK_UPDATE: begin
        mean_n   <= MN_W'(sum_new);
        mean_acc <= '0;
        mean_cnt <= '0;
      end
      emg_rms_pkg::BK_MEAN: begin
        if (mean_cnt != 2'(MEAN_CHUNKS)) begin
          mean_acc <= mean_acc_next;
          mean_n   <= {mean_n[MN_W-MC_W-1:0], {MC_W{1'b0}}};
          mean_cnt <= mean_cnt + 1'b1;
        end else begin
          s_r   <= mean_q;
          r     <= mean_q;
          it    <= '0;
          env_r <= '0;
        end
      end
      emg_rms_pkg::BK_ROOT: begin
        if (div_done) begin
          r     <= r_next;
          it    <= it + 1'b1;
          env_r <= (r_next > SUM_W'(emg_rms_pkg::ENV_MAX))
                   ? emg_rms_pkg::ENV_MAX : r_next[ENV_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register: a finished result waits here while the next item runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      envelope     <= env_r;
      channel_echo <= chin_r;
    end
  end
endmodule
`default_nettype wire

@@ sv/emg_bandpass_rms_envelope_core.sv @@
// Top level of the EMG band-pass and RMS envelope core.
// Instantiates emg_rms_front, emg_rms_fifo, emg_rms_back; uses emg_rms_pkg.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  channel_index, adc_sample
//   output   out_valid / out_stall envelope, channel_echo
//
// For each item the back part loads the channel state, runs the ten filter
// terms, squares, updates the window and takes the mean, runs the three Newton
// divisions (none when the mean square is zero) and hands the result over.
// After reset the ring and channel stores are cleared; in_stall is high
// during that pass. A two-entry queue takes items while the back part works;
// a held result waits in the output register while the next item is processed.
`default_nettype none
`include "emg_bandpass_rms_envelope_core_macros.svh"
module emg_bandpass_rms_envelope_core #(
  parameter int CHANNELS = emg_rms_pkg::CHANNELS_DEF,
  parameter int WINDOW   = emg_rms_pkg::WINDOW_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [emg_rms_pkg::CHIN_W-1:0]       channel_index,
  input  wire logic signed [emg_rms_pkg::RAW_W-1:0] adc_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [emg_rms_pkg::ENV_W-1:0]             envelope,
  output logic [emg_rms_pkg::CHIN_W-1:0]            channel_echo
);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW  = CHW + emg_rms_pkg::CHIN_W + emg_rms_pkg::Q_W;

  emg_rms_pkg::fifo_status_t fifo_st;
  emg_rms_pkg::back_ctl_t    back_ctl;
  logic                      push;
  logic [CHW-1:0]            f_ch, b_ch;
  logic [emg_rms_pkg::CHIN_W-1:0]     f_chin, b_chin;
  logic signed [emg_rms_pkg::Q_W-1:0] f_x, b_x;
  logic [IW-1:0]             q_rdata;

  emg_rms_front #(.CHANNELS(CHANNELS), .CHW(CHW)) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel_index (channel_index),
    .adc_sample    (adc_sample),
    .fifo_st       (fifo_st),
    .back_ctl      (back_ctl),
    .push          (push),
    .item_ch       (f_ch),
    .item_chin     (f_chin),
    .item_x        (f_x)
  );

  emg_rms_fifo #(.WIDTH(IW), .DEPTH(emg_rms_pkg::FIFO_DEPTH)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  ({f_ch, f_chin, f_x}),
    .pop    (back_ctl.pop),
    .rdata  (q_rdata),
    .status (fifo_st)
  );

  assign {b_ch, b_chin, b_x} = q_rdata;

  emg_rms_back #(.CHANNELS(CHANNELS), .WINDOW(WINDOW), .CHW(CHW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_st      (fifo_st),
    .item_ch      (b_ch),
    .item_chin    (b_chin),
    .item_x       (b_x),
    .ctl          (back_ctl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .envelope     (envelope),
    .channel_echo (channel_echo)
  );

  `EMG_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !fifo_st.full, "push while full")
  `EMG_ASSERT_IMPLY(a_no_underflow, clk, rst, back_ctl.pop, !fifo_st.empty, "pop while empty")
  `EMG_ASSERT_IMPLY(a_clear_idle, clk, rst, back_ctl.clearing, !back_ctl.pop && in_stall, "clear")
  `EMG_ASSERT(a_env_range, clk, rst, !out_valid || envelope <= emg_rms_pkg::ENV_MAX, "range")
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking bench for the EMG band-pass / sliding RMS envelope core.
// Needs emg_rms_pkg and emg_bandpass_rms_envelope_core; predicts every envelope.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int NUM_CH = 8;
  localparam int WIN = 10;
  localparam int N_RANDOM = 930;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [emg_rms_pkg::CHIN_W-1:0] chan;
    logic signed [emg_rms_pkg::RAW_W-1:0] raw;
    bit known;
    logic [emg_rms_pkg::ENV_W-1:0] env;
  } stim_row_t;

  typedef struct {
    logic [emg_rms_pkg::ENV_W-1:0] env;
    logic [emg_rms_pkg::CHIN_W-1:0] chan;
  } env_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [emg_rms_pkg::CHIN_W-1:0] channel_index;
  logic signed [emg_rms_pkg::RAW_W-1:0] adc_sample;
  logic out_valid;
  logic out_stall;
  logic [emg_rms_pkg::ENV_W-1:0] envelope;
  logic [emg_rms_pkg::CHIN_W-1:0] channel_echo;

  emg_bandpass_rms_envelope_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .channel_index(channel_index), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .envelope(envelope), .channel_echo(channel_echo)
  );

  // filter and window state, one copy per channel
  logic signed [15:0] x_hist [NUM_CH][2];
  logic signed [15:0] hp_hist [NUM_CH][2];
  logic signed [15:0] lp_hist [NUM_CH][2];
  longint sq_ring [NUM_CH][WIN];
  longint sq_total [NUM_CH];
  int ring_slot [NUM_CH];

  env_result_t pending_env[$];
  int mismatches;
  longint cycles;
  bit quiet_rx;
  bit hold_req;
  int hold_cnt;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] q15_mul(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    logic signed [31:0] p;
    logic signed [31:0] r;
    p = a * b;
    r = p >>> 15;
    if (r > 32767) return 16'sh7FFF;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  function automatic logic [emg_rms_pkg::ENV_W-1:0] predict_envelope(
      input logic [emg_rms_pkg::CHIN_W-1:0] chan,
      input logic signed [emg_rms_pkg::RAW_W-1:0] raw);
    int ch;
    logic signed [15:0] x;
    logic signed [15:0] hp;
    logic signed [15:0] lp;
    int acc;
    longint mag;
    longint sq;
    longint s;
    longint r;
    ch = chan % NUM_CH;
    x = {{2{raw[23]}}, raw[22:9]};
    acc = int'(q15_mul(emg_rms_pkg::HP_B0, x))
        + int'(q15_mul(emg_rms_pkg::HP_B1, x_hist[ch][0]))
        + int'(q15_mul(emg_rms_pkg::HP_B2, x_hist[ch][1]))
        - int'(q15_mul(emg_rms_pkg::HP_A1, hp_hist[ch][0]))
        - int'(q15_mul(emg_rms_pkg::HP_A2, hp_hist[ch][1]));
    hp = acc[15:0];
    // low-pass runs on the high-pass output history
    acc = int'(q15_mul(emg_rms_pkg::LP_B0, hp))
        + int'(q15_mul(emg_rms_pkg::LP_B1, hp_hist[ch][0]))
        + int'(q15_mul(emg_rms_pkg::LP_B2, hp_hist[ch][1]))
        - int'(q15_mul(emg_rms_pkg::LP_A1, lp_hist[ch][0]))
        - int'(q15_mul(emg_rms_pkg::LP_A2, lp_hist[ch][1]));
    lp = acc[15:0];
    x_hist[ch][1] = x_hist[ch][0];
    x_hist[ch][0] = x;
    hp_hist[ch][1] = hp_hist[ch][0];
    hp_hist[ch][0] = hp;
    lp_hist[ch][1] = lp_hist[ch][0];
    lp_hist[ch][0] = lp;
    mag = (lp < 0) ? -longint'(lp) : longint'(lp);
    sq = mag * mag;
    sq_total[ch] = sq_total[ch] - sq_ring[ch][ring_slot[ch]] + sq;
    sq_ring[ch][ring_slot[ch]] = sq;
    ring_slot[ch] = (ring_slot[ch] + 1) % WIN;
    s = sq_total[ch] / WIN;
    if (s > 0) begin
      r = s;
      for (int i = 0; i < emg_rms_pkg::NEWTON_STEPS; i++) begin
        r = (r + s / r) / 2;
        if (r == 0) r = 1;
      end
      s = r;
    end
    if (s > 32767) s = 32767;
    return s[emg_rms_pkg::ENV_W-1:0];
  endfunction

  // send one transaction, then, unless no_gap is set, maybe leave an idle gap
  task automatic send_sample(input logic [emg_rms_pkg::CHIN_W-1:0] chan,
                             input logic signed [emg_rms_pkg::RAW_W-1:0] raw,
                             input bit known, input logic [emg_rms_pkg::ENV_W-1:0] env,
                             input bit no_gap);
    env_result_t e;
    in_valid <= 1'b1;
    channel_index <= chan;
    adc_sample <= raw;
    do @(posedge clk); while (in_stall);
    e.env = predict_envelope(chan, raw);
    e.chan = chan;
    if (known && e.env !== env)
      $display("table row disagrees with prediction: ch %0d raw %0d", chan, raw);
    if (known) e.env = env;
    pending_env.push_back(e);
    if (!no_gap && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 600;
      out_stall <= 1'b1;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      if (hold_cnt == 1) hold_cnt <= -1;
      out_stall <= quiet_rx ? 1'b0 : ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk) begin
    env_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_env.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected envelope %0d on channel %0d", envelope, channel_echo);
      end else begin
        e = pending_env.pop_front();
        if (envelope !== e.env || channel_echo !== e.chan) begin
          mismatches++;
          if (mismatches <= 10)
            $display("envelope mismatch: exp %0d ch %0d, got %0d ch %0d",
                     e.env, e.chan, envelope, channel_echo);
        end
      end
    end
  end

  stim_row_t directed [] = '{
    '{3'd0, 24'sh000000, 1, 15'd0},
    '{3'd7, 24'sh000000, 1, 15'd0},
    '{3'd2, 24'sh0001FF, 1, 15'd0},
    '{3'd3, 24'shFFFE00, 0, 15'd0},
    '{3'd1, 24'sh7FFFFF, 0, 15'd0},
    '{3'd1, 24'sh800000, 0, 15'd0},
    '{3'd1, 24'sh7FFFFF, 0, 15'd0},
    '{3'd1, 24'sh800000, 0, 15'd0},
    '{3'd1, 24'sh7FFFFF, 0, 15'd0},
    '{3'd1, 24'sh800000, 0, 15'd0},
    '{3'd4, 24'sh800000, 0, 15'd0},
    '{3'd4, 24'sh800000, 0, 15'd0},
    '{3'd4, 24'sh800000, 0, 15'd0},
    '{3'd5, 24'sh7FFFFF, 0, 15'd0},
    '{3'd5, 24'sh7FFFFF, 0, 15'd0},
    '{3'd6, 24'sh000200, 0, 15'd0},
    '{3'd6, 24'shFFFFFF, 0, 15'd0},
    '{3'd6, 24'sh555555, 0, 15'd0},
    '{3'd6, 24'shAAAAAA, 0, 15'd0},
    '{3'd0, 24'sh400000, 0, 15'd0}
  };

  initial begin
    int amp;
    logic signed [emg_rms_pkg::RAW_W-1:0] raw;
    logic [emg_rms_pkg::CHIN_W-1:0] chan;
    rst = 1'b1;
    in_valid = 1'b0;
    channel_index = '0;
    adc_sample = '0;
    quiet_rx = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    cycles = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      x_hist[c] = '{0, 0};
      hp_hist[c] = '{0, 0};
      lp_hist[c] = '{0, 0};
      sq_total[c] = 0;
      ring_slot[c] = 0;
      for (int k = 0; k < WIN; k++) sq_ring[c][k] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_sample(directed[i].chan, directed[i].raw, directed[i].known, directed[i].env, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 130) hold_req = 1'b0;
      quiet_rx = (n >= 400 && n < 550);
      if (n == 300 || n == 700) begin
        // drain everything before resuming
        in_valid <= 1'b0;
        while (pending_env.size() != 0) @(posedge clk);
        repeat ($urandom_range(1, 200)) @(posedge clk);
      end
      chan = emg_rms_pkg::CHIN_W'($urandom_range(0, NUM_CH - 1));
      case ($urandom_range(0, 3))
        0: raw = emg_rms_pkg::RAW_W'($urandom);
        1: raw = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        default: begin
          // bounded-amplitude signal so the filters settle into realistic ranges
          amp = 1 << $urandom_range(9, 23);
          raw = emg_rms_pkg::RAW_W'($signed($urandom_range(0, amp - 1)) - (amp / 2));
        end
      endcase
      send_sample(chan, raw, 0, '0, n >= 400 && n < 550);
    end
    in_valid <= 1'b0;

    while (pending_env.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_env.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
